// File: design/pkpc_pkg.sv
// ----------------------------------------------------------------------------
// pkpc_pkg
// Shared types and constants for the packet protocol classifier and counter:
// class codes, header offsets, service ports and the result layout.
// ----------------------------------------------------------------------------
package pkpc_pkg;

  // Link class codes.
  localparam logic [1:0] LINK_OTHER = 2'd0;
  localparam logic [1:0] LINK_IPV4  = 2'd1;
  localparam logic [1:0] LINK_ARP   = 2'd2;

  // Transport class codes.
  localparam logic [1:0] TRANS_NONE = 2'd0;
  localparam logic [1:0] TRANS_ICMP = 2'd1;
  localparam logic [1:0] TRANS_TCP  = 2'd2;
  localparam logic [1:0] TRANS_UDP  = 2'd3;

  // Application class codes.
  localparam logic [2:0] APP_NONE = 3'd0;
  localparam logic [2:0] APP_DNS  = 3'd1;
  localparam logic [2:0] APP_SMTP = 3'd2;
  localparam logic [2:0] APP_POP  = 3'd3;
  localparam logic [2:0] APP_IMAP = 3'd4;
  localparam logic [2:0] APP_HTTP = 3'd5;

  // EtherType and IP protocol numbers.
  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETYPE_ARP  = 16'h0806;
  localparam logic [7:0]  PROTO_ICMP = 8'd1;
  localparam logic [7:0]  PROTO_TCP  = 8'd6;
  localparam logic [7:0]  PROTO_UDP  = 8'd17;

  // Well-known service ports.
  localparam logic [15:0] PORT_DNS  = 16'd53;
  localparam logic [15:0] PORT_SMTP = 16'd25;
  localparam logic [15:0] PORT_POP  = 16'd110;
  localparam logic [15:0] PORT_IMAP = 16'd143;
  localparam logic [15:0] PORT_HTTP = 16'd80;

  // Byte offsets within the frame.
  localparam int unsigned POS_ETYPE_HI = 12;
  localparam int unsigned POS_ETYPE_LO = 13;
  localparam int unsigned POS_IHL      = 14;
  localparam int unsigned POS_PROTO    = 23;
  localparam logic [6:0]  IP_HDR_BASE  = 7'd14;
  localparam logic [3:0]  IHL_MASK     = 4'hf;

  // Bits of the field-seen mask.
  localparam int unsigned SEEN_ETYPE = 0;
  localparam int unsigned SEEN_PROTO = 1;
  localparam int unsigned SEEN_SPORT = 2;
  localparam int unsigned SEEN_DPORT = 3;

  // Counter slots.
  localparam int unsigned NUM_CNT  = 9;
  localparam int unsigned CNT_IPV4 = 0;
  localparam int unsigned CNT_ARP  = 1;
  localparam int unsigned CNT_ICMP = 2;
  localparam int unsigned CNT_TCP  = 3;
  localparam int unsigned CNT_DNS  = 4;
  localparam int unsigned CNT_SMTP = 5;
  localparam int unsigned CNT_POP  = 6;
  localparam int unsigned CNT_IMAP = 7;
  localparam int unsigned CNT_HTTP = 8;

  // Classification of one finished frame, from the parser to the counters.
  typedef struct packed {
    logic                     fire;
    logic [1:0]               link;
    logic [1:0]               trans;
    logic [2:0]               app;
    logic [NUM_CNT-1:0]       bump;
  } frame_class_t;

  // One result beat as held in the output stages.
  typedef struct packed {
    logic [1:0]               link;
    logic [1:0]               trans;
    logic [2:0]               app;
    logic [NUM_CNT-1:0][31:0] totals;
  } result_t;

endpackage

// File: design/pkpc_in_if.sv
// ----------------------------------------------------------------------------
// pkpc_in_if
// Frame byte channel: one frame byte and its last-byte mark per beat.
// ----------------------------------------------------------------------------
interface pkpc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       end_of_frame;

  modport source (output valid, output frame_byte, output end_of_frame, input ready);
  modport sink   (input valid, input frame_byte, input end_of_frame, output ready);
endinterface

// File: design/pkpc_out_if.sv
// ----------------------------------------------------------------------------
// pkpc_out_if
// Result channel: the classes of one frame and all nine class counters.
// ----------------------------------------------------------------------------
interface pkpc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  link_class;
  logic [1:0]  transport_class;
  logic [2:0]  app_class;
  logic [31:0] ipv4_total;
  logic [31:0] arp_total;
  logic [31:0] icmp_total;
  logic [31:0] tcp_total;
  logic [31:0] dns_total;
  logic [31:0] smtp_total;
  logic [31:0] pop_total;
  logic [31:0] imap_total;
  logic [31:0] http_total;

  modport source (
    output valid, output link_class, output transport_class, output app_class,
    output ipv4_total, output arp_total, output icmp_total, output tcp_total,
    output dns_total, output smtp_total, output pop_total, output imap_total,
    output http_total, input ready
  );
  modport sink (
    input valid, input link_class, input transport_class, input app_class,
    input ipv4_total, input arp_total, input icmp_total, input tcp_total,
    input dns_total, input smtp_total, input pop_total, input imap_total,
    input http_total, output ready
  );
endinterface

// File: design/pkpc_parser.sv
// ----------------------------------------------------------------------------
// pkpc_parser
// Header field capture and frame classification. Tracks the byte position,
// captures EtherType, IHL, protocol and the two transport ports, and on the
// last byte of a frame reports its classes and which counters advance.
// ----------------------------------------------------------------------------
module pkpc_parser #(
  parameter int POS_BITS = 11
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  logic [7:0]           frame_byte,
  input  logic                 end_of_frame,
  output pkpc_pkg::frame_class_t cls
);

  logic [POS_BITS-1:0] pos_r, pos_nxt;
  logic [15:0]         etype_r, etype_nxt;
  logic [5:0]          ihl_bytes_r, ihl_bytes_nxt;
  logic [7:0]          proto_r, proto_nxt;
  logic [15:0]         sport_r, sport_nxt;
  logic [15:0]         dport_r, dport_nxt;
  logic [3:0]          seen_r, seen_nxt;
  logic [6:0]          tp_off;

  // True when a complete port on either side equals the given service port.
  function automatic logic port_hit(input logic [3:0] seen, input logic [15:0] sp,
                                    input logic [15:0] dp, input logic [15:0] port);
    port_hit = (seen[pkpc_pkg::SEEN_SPORT] && (sp == port)) ||
               (seen[pkpc_pkg::SEEN_DPORT] && (dp == port));
  endfunction

  // Field capture for the current byte.
  always_comb begin
    etype_nxt     = etype_r;
    ihl_bytes_nxt = ihl_bytes_r;
    proto_nxt     = proto_r;
    sport_nxt     = sport_r;
    dport_nxt     = dport_r;
    seen_nxt      = seen_r;

    if (pos_r == POS_BITS'(pkpc_pkg::POS_ETYPE_HI)) begin
      etype_nxt = {frame_byte, 8'h00};
    end
    if (pos_r == POS_BITS'(pkpc_pkg::POS_ETYPE_LO)) begin
      etype_nxt = {etype_r[15:8], frame_byte};
      seen_nxt[pkpc_pkg::SEEN_ETYPE] = 1'b1;
    end
    if (pos_r == POS_BITS'(pkpc_pkg::POS_IHL)) begin
      ihl_bytes_nxt = {frame_byte[3:0] & pkpc_pkg::IHL_MASK, 2'b00};
    end
    if (pos_r == POS_BITS'(pkpc_pkg::POS_PROTO)) begin
      proto_nxt = frame_byte;
      seen_nxt[pkpc_pkg::SEEN_PROTO] = 1'b1;
    end

    // The transport offset follows an IHL captured on this very byte.
    tp_off = pkpc_pkg::IP_HDR_BASE + {1'b0, ihl_bytes_nxt};
    if (pos_r == POS_BITS'(tp_off)) begin
      sport_nxt = {frame_byte, 8'h00};
    end
    if (pos_r == POS_BITS'(tp_off + 7'd1)) begin
      sport_nxt = {sport_r[15:8], frame_byte};
      seen_nxt[pkpc_pkg::SEEN_SPORT] = 1'b1;
    end
    if (pos_r == POS_BITS'(tp_off + 7'd2)) begin
      dport_nxt = {frame_byte, 8'h00};
    end
    if (pos_r == POS_BITS'(tp_off + 7'd3)) begin
      dport_nxt = {dport_r[15:8], frame_byte};
      seen_nxt[pkpc_pkg::SEEN_DPORT] = 1'b1;
    end

    // The position stops at its maximum on very long frames.
    pos_nxt = (pos_r == '1) ? pos_r : pos_r + POS_BITS'(1);
  end

  // Frame classification from the state as it stands after this byte.
  always_comb begin
    cls       = '0;
    cls.fire  = accept && end_of_frame;
    cls.link  = pkpc_pkg::LINK_OTHER;
    cls.trans = pkpc_pkg::TRANS_NONE;
    cls.app   = pkpc_pkg::APP_NONE;

    if (seen_nxt[pkpc_pkg::SEEN_ETYPE]) begin
      if (etype_nxt == pkpc_pkg::ETYPE_IPV4) begin
        cls.link = pkpc_pkg::LINK_IPV4;
      end else if (etype_nxt == pkpc_pkg::ETYPE_ARP) begin
        cls.link = pkpc_pkg::LINK_ARP;
      end
    end

    if (cls.link == pkpc_pkg::LINK_IPV4) begin
      cls.bump[pkpc_pkg::CNT_IPV4] = 1'b1;
      if (seen_nxt[pkpc_pkg::SEEN_PROTO]) begin
        case (proto_nxt)
          pkpc_pkg::PROTO_ICMP: begin
            cls.trans = pkpc_pkg::TRANS_ICMP;
            cls.bump[pkpc_pkg::CNT_ICMP] = 1'b1;
          end
          pkpc_pkg::PROTO_TCP: begin
            cls.trans = pkpc_pkg::TRANS_TCP;
            cls.bump[pkpc_pkg::CNT_TCP] = 1'b1;
            // Services are tested in a fixed priority order.
            if (port_hit(seen_nxt, sport_nxt, dport_nxt, pkpc_pkg::PORT_DNS)) begin
              cls.app = pkpc_pkg::APP_DNS;
              cls.bump[pkpc_pkg::CNT_DNS] = 1'b1;
            end else if (port_hit(seen_nxt, sport_nxt, dport_nxt, pkpc_pkg::PORT_SMTP)) begin
              cls.app = pkpc_pkg::APP_SMTP;
              cls.bump[pkpc_pkg::CNT_SMTP] = 1'b1;
            end else if (port_hit(seen_nxt, sport_nxt, dport_nxt, pkpc_pkg::PORT_POP)) begin
              cls.app = pkpc_pkg::APP_POP;
              cls.bump[pkpc_pkg::CNT_POP] = 1'b1;
            end else if (port_hit(seen_nxt, sport_nxt, dport_nxt, pkpc_pkg::PORT_IMAP)) begin
              cls.app = pkpc_pkg::APP_IMAP;
              cls.bump[pkpc_pkg::CNT_IMAP] = 1'b1;
            end else if (port_hit(seen_nxt, sport_nxt, dport_nxt, pkpc_pkg::PORT_HTTP)) begin
              cls.app = pkpc_pkg::APP_HTTP;
              cls.bump[pkpc_pkg::CNT_HTTP] = 1'b1;
            end
          end
          pkpc_pkg::PROTO_UDP: begin
            cls.trans = pkpc_pkg::TRANS_UDP;
            // Over UDP only the destination port identifies DNS.
            if (seen_nxt[pkpc_pkg::SEEN_DPORT] && (dport_nxt == pkpc_pkg::PORT_DNS)) begin
              cls.app = pkpc_pkg::APP_DNS;
              cls.bump[pkpc_pkg::CNT_DNS] = 1'b1;
            end
          end
          default: begin
            cls.trans = pkpc_pkg::TRANS_NONE;
          end
        endcase
      end
    end else if (cls.link == pkpc_pkg::LINK_ARP) begin
      cls.bump[pkpc_pkg::CNT_ARP] = 1'b1;
    end
  end

  // Per-frame state; the last byte of a frame clears it for the next one.
  always_ff @(posedge clk) begin
    if (!rst_n || (accept && end_of_frame)) begin
      pos_r       <= '0;
      etype_r     <= '0;
      ihl_bytes_r <= '0;
      proto_r     <= '0;
      sport_r     <= '0;
      dport_r     <= '0;
      seen_r      <= '0;
    end else if (accept) begin
      pos_r       <= pos_nxt;
      etype_r     <= etype_nxt;
      ihl_bytes_r <= ihl_bytes_nxt;
      proto_r     <= proto_nxt;
      sport_r     <= sport_nxt;
      dport_r     <= dport_nxt;
      seen_r      <= seen_nxt;
    end
  end

endmodule

// File: design/packet_protocol_classifier_counter.sv
// ----------------------------------------------------------------------------
// packet_protocol_classifier_counter
// Ethernet/IPv4 header classifier with nine wrapping class counters.
// ----------------------------------------------------------------------------
// The block takes one frame byte per beat; each byte is captured and classified
// by a compare against the byte position. The edge that accepts the last byte
// of a frame loads its result into the output register, offered in the next
// cycle, or into the skid register while an earlier result waits untaken. A
// result beat carries the frame's link, transport and application classes and
// all nine counters after this frame's update. The result side has an output
// register and a skid register, so bytes keep flowing while a result waits;
// in_bus.ready falls only while both hold a result that has not been taken.
// Counters are COUNT_BITS wide and wrap; the result shows their low 32 bits.
// The byte position is POS_BITS wide and saturates on long frames.
// ----------------------------------------------------------------------------
module packet_protocol_classifier_counter #(
  parameter int COUNT_BITS = 32,
  parameter int POS_BITS   = 11
) (
  input  logic              clk,
  input  logic              rst_n,
  pkpc_in_if.sink           in_bus,
  pkpc_out_if.source        out_bus
);

  localparam int NCNT = pkpc_pkg::NUM_CNT;

  pkpc_pkg::frame_class_t cls;
  pkpc_pkg::result_t      res_nxt;
  pkpc_pkg::result_t      out_data_r;
  pkpc_pkg::result_t      skid_data_r;
  logic                   out_valid_r;
  logic                   skid_valid_r;
  logic                   in_accept;
  logic [COUNT_BITS-1:0]  cnt_r   [NCNT];
  logic [COUNT_BITS-1:0]  cnt_nxt [NCNT];

  // Input side stalls only when both result slots are occupied.
  assign in_bus.ready = !skid_valid_r;
  assign in_accept    = in_bus.valid && in_bus.ready;

  // Field capture and classification.
  pkpc_parser #(
    .POS_BITS (POS_BITS)
  ) u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (in_accept),
    .frame_byte   (in_bus.frame_byte),
    .end_of_frame (in_bus.end_of_frame),
    .cls          (cls)
  );

  // Counter update and the result that goes with it.
  always_comb begin
    res_nxt.link  = cls.link;
    res_nxt.trans = cls.trans;
    res_nxt.app   = cls.app;
    for (int i = 0; i < NCNT; i++) begin
      cnt_nxt[i]        = cnt_r[i] + COUNT_BITS'(cls.bump[i]);
      res_nxt.totals[i] = 32'(cnt_nxt[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NCNT; i++) begin
        cnt_r[i] <= '0;
      end
    end else if (cls.fire) begin
      for (int i = 0; i < NCNT; i++) begin
        cnt_r[i] <= cnt_nxt[i];
      end
    end
  end

  // Output register with a skid register behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_bus.ready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r  <= cls.fire;
      end
    end else if (cls.fire) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_bus.ready) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
      end else if (cls.fire) begin
        out_data_r <= res_nxt;
      end
    end else if (cls.fire) begin
      skid_data_r <= res_nxt;
    end
  end

  // Result channel.
  assign out_bus.valid           = out_valid_r;
  assign out_bus.link_class      = out_data_r.link;
  assign out_bus.transport_class = out_data_r.trans;
  assign out_bus.app_class       = out_data_r.app;
  assign out_bus.ipv4_total      = out_data_r.totals[pkpc_pkg::CNT_IPV4];
  assign out_bus.arp_total       = out_data_r.totals[pkpc_pkg::CNT_ARP];
  assign out_bus.icmp_total      = out_data_r.totals[pkpc_pkg::CNT_ICMP];
  assign out_bus.tcp_total       = out_data_r.totals[pkpc_pkg::CNT_TCP];
  assign out_bus.dns_total       = out_data_r.totals[pkpc_pkg::CNT_DNS];
  assign out_bus.smtp_total      = out_data_r.totals[pkpc_pkg::CNT_SMTP];
  assign out_bus.pop_total       = out_data_r.totals[pkpc_pkg::CNT_POP];
  assign out_bus.imap_total      = out_data_r.totals[pkpc_pkg::CNT_IMAP];
  assign out_bus.http_total      = out_data_r.totals[pkpc_pkg::CNT_HTTP];

  // The skid register is only ever occupied behind a full output register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register holds a result while the output register is empty");

  // A service class is only ever reported over TCP or UDP.
  a_app_needs_transport: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.app != pkpc_pkg::APP_NONE)) |->
    ((out_data_r.trans == pkpc_pkg::TRANS_TCP) || (out_data_r.trans == pkpc_pkg::TRANS_UDP)))
    else $error("application class without a TCP or UDP transport");

  // A transport class is only ever reported for IPv4 frames.
  a_transport_needs_ipv4: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.trans != pkpc_pkg::TRANS_NONE)) |->
    (out_data_r.link == pkpc_pkg::LINK_IPV4))
    else $error("transport class on a frame that is not IPv4");

  // A result beat never appears straight out of reset.
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("result valid in the cycle after reset");

endmodule

// File: sim/pkpc_frame_checker.sv
// ----------------------------------------------------------------------------
// pkpc_frame_checker
// Watches both channels of the packet classifier, predicts the result of
// every frame from the accepted byte beats and compares it with the result
// beats, field by field, in order.
// ----------------------------------------------------------------------------
module pkpc_frame_checker #(
  parameter int COUNT_BITS = 32,
  parameter int POS_BITS   = 11
) (
  input  logic        clk,
  input  logic        rst_n,
  pkpc_in_if          in_bus,
  pkpc_out_if         out_bus,
  output int unsigned mismatches,
  output int unsigned frames_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned POS_LIMIT     = (1 << POS_BITS) - 1;
  localparam int unsigned REPORT_LIMIT  = 10;

  // Parser state of the frame in flight.
  int unsigned           byte_pos;
  logic [15:0]           etype_seen;
  logic [5:0]            hdr_len;
  logic [7:0]            proto_seen;
  logic [15:0]           sport_seen;
  logic [15:0]           dport_seen;
  logic [3:0]            seen_mask;
  logic [COUNT_BITS-1:0] class_count [pkpc_pkg::NUM_CNT];

  // Predicted results still waiting for their beat.
  pkpc_pkg::result_t expected_results [$];

  task automatic clear_frame_state();
    byte_pos   = 0;
    etype_seen = '0;
    hdr_len    = '0;
    proto_seen = '0;
    sport_seen = '0;
    dport_seen = '0;
    seen_mask  = '0;
  endtask

  task automatic count_up(input int unsigned slot);
    class_count[slot] = class_count[slot] + 1'b1;
  endtask

  // A service port matches only on a port whose two bytes both arrived.
  function automatic logic port_hit(input logic [15:0] port);
    return (seen_mask[pkpc_pkg::SEEN_SPORT] && sport_seen == port) ||
           (seen_mask[pkpc_pkg::SEEN_DPORT] && dport_seen == port);
  endfunction

  // Capture one accepted byte; on the last byte, classify and queue a result.
  task automatic parse_byte(input logic [7:0] b, input logic last);
    int unsigned       tport;
    logic [1:0]        link;
    logic [1:0]        trans;
    logic [2:0]        app;
    pkpc_pkg::result_t res;
    if (byte_pos == pkpc_pkg::POS_ETYPE_HI) etype_seen = {b, 8'h00};
    if (byte_pos == pkpc_pkg::POS_ETYPE_LO) begin
      etype_seen[7:0] = b;
      seen_mask[pkpc_pkg::SEEN_ETYPE] = 1'b1;
    end
    if (byte_pos == pkpc_pkg::POS_IHL) hdr_len = {b[3:0], 2'b00};
    if (byte_pos == pkpc_pkg::POS_PROTO) begin
      proto_seen = b;
      seen_mask[pkpc_pkg::SEEN_PROTO] = 1'b1;
    end

    // The transport offset follows the header length captured so far,
    // including one captured from this very byte.
    tport = pkpc_pkg::POS_IHL + hdr_len;
    if (byte_pos == tport) sport_seen = {b, 8'h00};
    if (byte_pos == tport + 1) begin
      sport_seen[7:0] = b;
      seen_mask[pkpc_pkg::SEEN_SPORT] = 1'b1;
    end
    if (byte_pos == tport + 2) dport_seen = {b, 8'h00};
    if (byte_pos == tport + 3) begin
      dport_seen[7:0] = b;
      seen_mask[pkpc_pkg::SEEN_DPORT] = 1'b1;
    end

    if (byte_pos < POS_LIMIT) byte_pos++;

    if (last) begin
      link  = pkpc_pkg::LINK_OTHER;
      trans = pkpc_pkg::TRANS_NONE;
      app   = pkpc_pkg::APP_NONE;
      if (seen_mask[pkpc_pkg::SEEN_ETYPE]) begin
        if (etype_seen == pkpc_pkg::ETYPE_IPV4) link = pkpc_pkg::LINK_IPV4;
        else if (etype_seen == pkpc_pkg::ETYPE_ARP) link = pkpc_pkg::LINK_ARP;
      end

      if (link == pkpc_pkg::LINK_IPV4) begin
        count_up(pkpc_pkg::CNT_IPV4);
        if (seen_mask[pkpc_pkg::SEEN_PROTO]) begin
          if (proto_seen == pkpc_pkg::PROTO_ICMP) begin
            trans = pkpc_pkg::TRANS_ICMP;
            count_up(pkpc_pkg::CNT_ICMP);
          end else if (proto_seen == pkpc_pkg::PROTO_TCP) begin
            trans = pkpc_pkg::TRANS_TCP;
            count_up(pkpc_pkg::CNT_TCP);
            // Services are tried in a fixed order; the first hit wins.
            if (port_hit(pkpc_pkg::PORT_DNS)) begin
              app = pkpc_pkg::APP_DNS;
              count_up(pkpc_pkg::CNT_DNS);
            end else if (port_hit(pkpc_pkg::PORT_SMTP)) begin
              app = pkpc_pkg::APP_SMTP;
              count_up(pkpc_pkg::CNT_SMTP);
            end else if (port_hit(pkpc_pkg::PORT_POP)) begin
              app = pkpc_pkg::APP_POP;
              count_up(pkpc_pkg::CNT_POP);
            end else if (port_hit(pkpc_pkg::PORT_IMAP)) begin
              app = pkpc_pkg::APP_IMAP;
              count_up(pkpc_pkg::CNT_IMAP);
            end else if (port_hit(pkpc_pkg::PORT_HTTP)) begin
              app = pkpc_pkg::APP_HTTP;
              count_up(pkpc_pkg::CNT_HTTP);
            end
          end else if (proto_seen == pkpc_pkg::PROTO_UDP) begin
            trans = pkpc_pkg::TRANS_UDP;
            // UDP only counts DNS, and only on the destination port.
            if (seen_mask[pkpc_pkg::SEEN_DPORT] && dport_seen == pkpc_pkg::PORT_DNS) begin
              app = pkpc_pkg::APP_DNS;
              count_up(pkpc_pkg::CNT_DNS);
            end
          end
        end
      end else if (link == pkpc_pkg::LINK_ARP) begin
        count_up(pkpc_pkg::CNT_ARP);
      end

      res.link  = link;
      res.trans = trans;
      res.app   = app;
      for (int i = 0; i < pkpc_pkg::NUM_CNT; i++) res.totals[i] = 32'(class_count[i]);
      expected_results.push_back(res);
      clear_frame_state();
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("%t: %s mismatch: expected %0d, got %0d", $realtime, name, want, got);
    end
  endtask

  // Compare one result beat with the oldest prediction.
  task automatic compare_result();
    pkpc_pkg::result_t want;
    if (expected_results.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("%t: result beat with no frame outstanding: link %0d trans %0d app %0d",
                 $realtime, out_bus.link_class, out_bus.transport_class,
                 out_bus.app_class);
    end else begin
      want = expected_results.pop_front();
      check_field("link_class", 32'(want.link), 32'(out_bus.link_class));
      check_field("transport_class", 32'(want.trans), 32'(out_bus.transport_class));
      check_field("app_class", 32'(want.app), 32'(out_bus.app_class));
      check_field("ipv4_total", want.totals[pkpc_pkg::CNT_IPV4], out_bus.ipv4_total);
      check_field("arp_total",  want.totals[pkpc_pkg::CNT_ARP],  out_bus.arp_total);
      check_field("icmp_total", want.totals[pkpc_pkg::CNT_ICMP], out_bus.icmp_total);
      check_field("tcp_total",  want.totals[pkpc_pkg::CNT_TCP],  out_bus.tcp_total);
      check_field("dns_total",  want.totals[pkpc_pkg::CNT_DNS],  out_bus.dns_total);
      check_field("smtp_total", want.totals[pkpc_pkg::CNT_SMTP], out_bus.smtp_total);
      check_field("pop_total",  want.totals[pkpc_pkg::CNT_POP],  out_bus.pop_total);
      check_field("imap_total", want.totals[pkpc_pkg::CNT_IMAP], out_bus.imap_total);
      check_field("http_total", want.totals[pkpc_pkg::CNT_HTTP], out_bus.http_total);
    end
  endtask

  // Sample both channels at each rising edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_frame_state();
      for (int i = 0; i < pkpc_pkg::NUM_CNT; i++) class_count[i] = '0;
      expected_results.delete();
    end else begin
      if (in_bus.valid && in_bus.ready) parse_byte(in_bus.frame_byte, in_bus.end_of_frame);
      if (out_bus.valid && out_bus.ready) compare_result();
    end
    frames_pending <= expected_results.size();
  end

endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives Ethernet frames byte by byte into the packet classifier: a directed
// set of frames for each class, port order and short-frame case, then random
// well-formed, cut-off and noise frames with random gaps and result stalls,
// including one long hold-off on the result side. The frame checker beside
// the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned DRAIN_CYCLES  = 16;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned TARGET_BYTES  = 2000;
  localparam int unsigned TARGET_FRAMES = 24;
  localparam int unsigned MAX_GAP       = 17;

  typedef enum logic [1:0] {GAP_NONE, GAP_FULL, GAP_LIGHT} gap_style_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        hold_req = 1'b0;
  logic        long_hold = 1'b0;
  int unsigned mismatches;
  int unsigned frames_pending;
  int unsigned bytes_sent;
  int unsigned cycle_count;
  gap_style_t  gap_style;
  logic [7:0]  frame_buf [$];

  pkpc_in_if  byte_chan ();
  pkpc_out_if result_chan ();

  packet_protocol_classifier_counter dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (byte_chan),
    .out_bus (result_chan)
  );

  pkpc_frame_checker frame_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_bus         (byte_chan),
    .out_bus        (result_chan),
    .mismatches     (mismatches),
    .frames_pending (frames_pending)
  );

  always #4 clk = ~clk;

  // Run limit.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Long result-side hold-off, counted here once the stimulus asks for it.
  initial begin
    wait (hold_req);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    long_hold <= 1'b0;
  end

  // Result side: a random stall before each beat, with calm stretches.
  initial begin
    int unsigned stall;
    logic        calm;
    calm = 1'b0;
    result_chan.ready <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 15) == 0) calm = !calm;
      stall = calm ? 0 : $urandom_range(0, MAX_GAP);
      if (stall != 0 || long_hold) begin
        result_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
        while (long_hold) @(posedge clk);
      end
      result_chan.ready <= 1'b1;
      do @(posedge clk); while (!result_chan.valid && !long_hold);
    end
  end

  function automatic int unsigned draw_gap();
    case (gap_style)
      GAP_NONE:  return 0;
      GAP_FULL:  return $urandom_range(0, MAX_GAP);
      default:   return ($urandom_range(0, 4) == 0) ? $urandom_range(1, MAX_GAP) : 0;
    endcase
  endfunction

  function automatic logic [15:0] pick_port();
    case ($urandom_range(0, 6))
      0:       return pkpc_pkg::PORT_DNS;
      1:       return pkpc_pkg::PORT_SMTP;
      2:       return pkpc_pkg::PORT_POP;
      3:       return pkpc_pkg::PORT_IMAP;
      4:       return pkpc_pkg::PORT_HTTP;
      default: return 16'($urandom);
    endcase
  endfunction

  // Offer one byte beat, after a drawn gap, and wait until it is taken.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int unsigned gap;
    gap = draw_gap();
    if (gap != 0) begin
      byte_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_chan.valid        <= 1'b1;
    byte_chan.frame_byte   <= b;
    byte_chan.end_of_frame <= last;
    do @(posedge clk); while (!byte_chan.ready);
    bytes_sent++;
  endtask

  task automatic send_frame();
    int unsigned idx;
    for (idx = 0; idx < frame_buf.size(); idx++)
      send_byte(frame_buf[idx], idx == frame_buf.size() - 1);
  endtask

  // Lay out a frame with the given header fields over random bytes. A cut
  // of zero keeps the whole frame; otherwise the frame ends after cut bytes.
  // Where the header is short, the port bytes may overwrite earlier fields.
  task automatic make_frame(input logic [15:0] etype, input logic [3:0] ihl,
                            input logic [7:0] proto, input logic [15:0] sport,
                            input logic [15:0] dport, input int unsigned extra,
                            input int unsigned cut);
    int unsigned tport;
    int unsigned len;
    tport = pkpc_pkg::POS_IHL + 4 * ihl;
    len = tport + 4;
    if (len < pkpc_pkg::POS_PROTO + 1) len = pkpc_pkg::POS_PROTO + 1;
    len += extra;
    frame_buf.delete();
    repeat (len) frame_buf.push_back(8'($urandom));
    frame_buf[pkpc_pkg::POS_ETYPE_HI] = etype[15:8];
    frame_buf[pkpc_pkg::POS_ETYPE_LO] = etype[7:0];
    frame_buf[pkpc_pkg::POS_IHL]      = {4'h4, ihl};
    frame_buf[pkpc_pkg::POS_PROTO]    = proto;
    frame_buf[tport]                  = sport[15:8];
    frame_buf[tport + 1]              = sport[7:0];
    frame_buf[tport + 2]              = dport[15:8];
    frame_buf[tport + 3]              = dport[7:0];
    if (cut != 0)
      while (frame_buf.size() > cut) void'(frame_buf.pop_back());
  endtask

  task automatic make_noise(input int unsigned len, input logic fixed,
                            input logic [7:0] fill);
    frame_buf.delete();
    repeat (len) frame_buf.push_back(fixed ? fill : 8'($urandom));
  endtask

  // A random frame shaped to get past the header: mostly IPv4 with service
  // ports, sometimes with an odd header length, optionally cut short.
  task automatic make_random_frame(input logic truncate);
    logic [15:0] etype;
    logic [7:0]  proto;
    logic [3:0]  ihl;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    etype = (pick < 70) ? pkpc_pkg::ETYPE_IPV4 :
            (pick < 85) ? pkpc_pkg::ETYPE_ARP : 16'($urandom);
    case ($urandom_range(0, 4))
      0:       proto = pkpc_pkg::PROTO_ICMP;
      1, 2:    proto = pkpc_pkg::PROTO_TCP;
      3:       proto = pkpc_pkg::PROTO_UDP;
      default: proto = 8'($urandom);
    endcase
    ihl = ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'd5;
    make_frame(etype, ihl, proto, pick_port(), pick_port(), $urandom_range(0, 12), 0);
    if (truncate)
      make_frame(etype, ihl, proto, pick_port(), pick_port(), 0,
                 $urandom_range(1, frame_buf.size()));
  endtask

  initial begin
    int unsigned frames_made;
    int unsigned kind;
    rst_n                  <= 1'b0;
    byte_chan.valid        <= 1'b0;
    byte_chan.frame_byte   <= '0;
    byte_chan.end_of_frame <= 1'b0;
    bytes_sent  = 0;
    frames_made = 0;
    gap_style   = GAP_LIGHT;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed frames: each service, port order, UDP rules, other classes.
    make_frame(pkpc_pkg::ETYPE_IPV4, 4'd5, pkpc_pkg::PROTO_TCP,
               pkpc_pkg::PORT_DNS, pkpc_pkg::PORT_HTTP, 0, 0);
    send_frame();
    make_frame(pkpc_pkg::ETYPE_IPV4, 4'd5, pkpc_pkg::PROTO_TCP,
               16'd4000, pkpc_pkg::PORT_SMTP, 2, 0);
    send_frame();
    make_frame(pkpc_pkg::ETYPE_IPV4, 4'd5, pkpc_pkg::PROTO_TCP,
               pkpc_pkg::PORT_POP, 16'hffff, 0, 0);
    send_frame();
    make_frame(pkpc_pkg::ETYPE_IPV4, 4'd5, pkpc_pkg::PROTO_TCP,
               16'h0000, pkpc_pkg::PORT_IMAP, 0, 0);
    send_frame();
    make_frame(pkpc_pkg::ETYPE_IPV4, 4'd5, pkpc_pkg::PROTO_TCP,
               pkpc_pkg::PORT_HTTP, 16'd1024, 1, 0);
    send_frame();
    make_frame(pkpc_pkg::ETYPE_IPV4, 4'd5, pkpc_pkg::PROTO_TCP,
               pkpc_pkg::PORT_SMTP, pkpc_pkg::PORT_DNS, 0, 0);
    send_frame();
    make_frame(pkpc_pkg::ETYPE_IPV4, 4'd5, pkpc_pkg::PROTO_TCP,
               pkpc_pkg::PORT_IMAP, pkpc_pkg::PORT_POP, 0, 0);
    send_frame();
    make_frame(pkpc_pkg::ETYPE_IPV4, 4'd5, pkpc_pkg::PROTO_UDP,
               16'd5353, pkpc_pkg::PORT_DNS, 0, 0);
    send_frame();
    make_frame(pkpc_pkg::ETYPE_IPV4, 4'd5, pkpc_pkg::PROTO_UDP,
               pkpc_pkg::PORT_DNS, 16'd1000, 0, 0);
    send_frame();
    make_frame(pkpc_pkg::ETYPE_IPV4, 4'd5, pkpc_pkg::PROTO_ICMP,
               pkpc_pkg::PORT_HTTP, pkpc_pkg::PORT_DNS, 0, 0);
    send_frame();
    make_frame(pkpc_pkg::ETYPE_IPV4, 4'd5, 8'hff,
               pkpc_pkg::PORT_DNS, pkpc_pkg::PORT_DNS, 0, 0);
    send_frame();
    make_frame(pkpc_pkg::ETYPE_ARP, 4'd5, pkpc_pkg::PROTO_TCP,
               pkpc_pkg::PORT_DNS, pkpc_pkg::PORT_DNS, 0, 0);
    send_frame();
    make_frame(16'h86dd, 4'd5, pkpc_pkg::PROTO_TCP,
               pkpc_pkg::PORT_HTTP, pkpc_pkg::PORT_HTTP, 0, 0);
    send_frame();

    // Short frames: a single byte, an incomplete EtherType, no protocol
    // byte, and a destination port missing its low byte.
    make_noise(1, 1'b1, 8'hff);
    send_frame();
    make_frame(pkpc_pkg::ETYPE_IPV4, 4'd5, pkpc_pkg::PROTO_TCP,
               pkpc_pkg::PORT_DNS, pkpc_pkg::PORT_DNS, 0, 13);
    send_frame();
    make_frame(pkpc_pkg::ETYPE_IPV4, 4'd5, pkpc_pkg::PROTO_TCP,
               pkpc_pkg::PORT_DNS, pkpc_pkg::PORT_DNS, 0, 20);
    send_frame();
    make_frame(pkpc_pkg::ETYPE_IPV4, 4'd5, pkpc_pkg::PROTO_TCP,
               16'd1234, pkpc_pkg::PORT_HTTP, 0, 37);
    send_frame();

    // Header lengths below the minimum, and the largest one.
    make_frame(pkpc_pkg::ETYPE_IPV4, 4'd0, pkpc_pkg::PROTO_TCP,
               pkpc_pkg::PORT_DNS, 16'h1234, 0, 0);
    send_frame();
    make_frame(pkpc_pkg::ETYPE_IPV4, 4'd2, pkpc_pkg::PROTO_TCP,
               16'h0006, pkpc_pkg::PORT_SMTP, 0, 0);
    send_frame();
    make_frame(pkpc_pkg::ETYPE_IPV4, 4'd15, pkpc_pkg::PROTO_TCP,
               16'hffff, pkpc_pkg::PORT_HTTP, 0, 0);
    send_frame();

    // Field extremes: all-zero and all-ones frames.
    make_noise(30, 1'b1, 8'h00);
    send_frame();
    make_noise(30, 1'b1, 8'hff);
    send_frame();

    // Random frames until enough bytes and results have gone through.
    while (bytes_sent < TARGET_BYTES || frames_made < TARGET_FRAMES) begin
      case ($urandom_range(0, 3))
        0:       gap_style = GAP_NONE;
        1:       gap_style = GAP_FULL;
        default: gap_style = GAP_LIGHT;
      endcase

      if (frames_made == 10) begin
        // One frame long enough to saturate the byte position.
        gap_style = GAP_NONE;
        make_frame(pkpc_pkg::ETYPE_IPV4, 4'd5, pkpc_pkg::PROTO_TCP,
                   16'($urandom), pkpc_pkg::PORT_HTTP, 2100, 0);
        send_frame();
      end else if (frames_made == 20) begin
        // Flood tiny frames while the result side is held off.
        hold_req  <= 1'b1;
        gap_style = GAP_NONE;
        repeat (12) begin
          make_noise($urandom_range(1, 4), 1'b0, 8'h00);
          send_frame();
        end
      end else begin
        kind = $urandom_range(0, 99);
        if (kind < 65) make_random_frame(1'b0);
        else if (kind < 85) make_random_frame(1'b1);
        else make_noise($urandom_range(1, 40), 1'b0, 8'h00);
        send_frame();
      end
      frames_made++;
    end

    // Drain and give the verdict.
    byte_chan.valid <= 1'b0;
    do @(posedge clk); while (frames_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && frames_pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: files.f
design/pkpc_pkg.sv
design/pkpc_in_if.sv
design/pkpc_out_if.sv
design/pkpc_parser.sv
design/packet_protocol_classifier_counter.sv
sim/pkpc_frame_checker.sv
sim/tb_top.sv
